@@ rtl/atd_pkg.sv @@
// Shared types and constants for the accelerometer tap detector.
`default_nettype none

package atd_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEFAULT = 8;
    localparam int COUNT_WIDTH_DEFAULT  = 8;

    // Fixed field widths.
    localparam int THRESHOLD_W   = 7;
    localparam int DEBOUNCE_W    = 8;
    localparam int WINDOW_W      = 8;
    localparam int TAP_COUNT_W   = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_WINDOW      = 2'd2;

    // Register values after reset.
    localparam logic [THRESHOLD_W-1:0] TAP_THRESHOLD_RESET   = 7'd20;
    localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_LENGTH_RESET = 8'd45;
    localparam logic [WINDOW_W-1:0]    TAP_WINDOW_RESET      = 8'd5;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] tap_threshold;
        logic [DEBOUNCE_W-1:0]  debounce_length;
        logic [WINDOW_W-1:0]    tap_window;
    } atd_cfg_t;

    typedef struct packed {
        logic [TAP_COUNT_W-1:0] tap_count;
        logic                   tap_seen;
    } atd_result_t;

endpackage

`default_nettype wire

@@ rtl/accel_tap_detector_top.sv @@
// Top level of the accelerometer tap detector with its stream ports.
`default_nettype none

// The block takes a stream of signed Z-axis accelerometer samples and returns
// one result per sample: the running tap count, a flag that the sample
// completed a tap, and a copy of the burst end marker on tlast. Each sample is
// halved and differenced against the previous halved sample; a difference
// beyond the threshold arms a debounce countdown, and an opposite swing inside
// the tap window counts one tap. The block accepts one sample transfer in
// every clock cycle when the result side keeps up. A sample is captured in an
// input register and its result is registered in the output register once
// that register is free; the combinational detector logic between those two
// registers sets the rate.
// A result waiting for the downstream side does not block the input register
// from holding the following sample. Configuration writes are always ready
// and should only be issued while no sample is in flight.
module accel_tap_detector_top #(
    parameter int SAMPLE_WIDTH = atd_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = atd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Sample input stream.
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // tdata: z_sample in the low SAMPLE_WIDTH bits, zero padding above.
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tlast,   // last_in_burst
    // Result output stream.
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [atd_pkg::TAP_COUNT_W-1:0]   m_axis_tdata,   // tap_count
    output      logic                              m_axis_tuser,   // tap_seen
    output      logic                              m_axis_tlast,   // report_now
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [atd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [atd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import atd_pkg::*;

    atd_cfg_t    cfg;
    atd_result_t result;

    // Input register holding one accepted sample.
    logic                    in_valid_reg, in_valid_next;
    logic [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                    in_last_reg;

    // Output register holding one finished result.
    logic                    out_valid_reg, out_valid_next;
    logic [TAP_COUNT_W-1:0]  out_count_reg;
    logic                    out_seen_reg;
    logic                    out_last_reg;

    logic                    s_xfer;
    logic                    advance;

    // The held sample moves into the output register when that register is
    // empty or its result is being taken in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign cfg_ready = 1'b1;

    atd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    atd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .z_sample (in_sample_reg),
        .cfg      (cfg),
        .result   (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_sample_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            in_last_reg   <= s_axis_tlast;
        end
        if (advance) begin
            out_count_reg <= result.tap_count;
            out_seen_reg  <= result.tap_seen;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_seen_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/atd_cfg_regs.sv @@
// Configuration register file of the tap detector.
`default_nettype none

module atd_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [atd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [atd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output atd_pkg::atd_cfg_t                   cfg
);
    import atd_pkg::*;

    logic [THRESHOLD_W-1:0] tap_threshold_reg,   tap_threshold_next;
    logic [DEBOUNCE_W-1:0]  debounce_length_reg, debounce_length_next;
    logic [WINDOW_W-1:0]    tap_window_reg,      tap_window_next;

    always_comb begin
        tap_threshold_next   = tap_threshold_reg;
        debounce_length_next = debounce_length_reg;
        tap_window_next      = tap_window_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TAP_THRESHOLD:   tap_threshold_next   = cfg_data[THRESHOLD_W-1:0];
                REG_DEBOUNCE_LENGTH: debounce_length_next = cfg_data[DEBOUNCE_W-1:0];
                REG_TAP_WINDOW:      tap_window_next      = cfg_data[WINDOW_W-1:0];
                default: begin
                    // Unknown index: the write is dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_threshold_reg   <= TAP_THRESHOLD_RESET;
            debounce_length_reg <= DEBOUNCE_LENGTH_RESET;
            tap_window_reg      <= TAP_WINDOW_RESET;
        end else begin
            tap_threshold_reg   <= tap_threshold_next;
            debounce_length_reg <= debounce_length_next;
            tap_window_reg      <= tap_window_next;
        end
    end

    assign cfg.tap_threshold   = tap_threshold_reg;
    assign cfg.debounce_length = debounce_length_reg;
    assign cfg.tap_window      = tap_window_reg;

endmodule

`default_nettype wire

@@ rtl/atd_core.sv @@
// Tap detection datapath: halving, differencing, swing compare and debounce state.
`default_nettype none

module atd_core #(
    parameter int SAMPLE_WIDTH = atd_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = atd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    input  wire logic [SAMPLE_WIDTH-1:0] z_sample,
    input  wire atd_pkg::atd_cfg_t       cfg,
    output atd_pkg::atd_result_t         result
);
    import atd_pkg::*;

    localparam int HALF_W  = SAMPLE_WIDTH - 1;
    localparam int CMP_W   = SAMPLE_WIDTH + 1;
    localparam int CEXT_W  = (COUNT_WIDTH > TAP_COUNT_W) ? COUNT_WIDTH : TAP_COUNT_W;

    logic signed [HALF_W-1:0]   prev_half_reg, prev_half_next;
    logic [DEBOUNCE_W-1:0]      debounce_left_reg, debounce_left_next;
    logic                       first_pos_reg, first_pos_next;
    logic [COUNT_WIDTH-1:0]     taps_reg, taps_next;

    logic signed [HALF_W-1:0]   half_now;
    logic signed [CMP_W-1:0]    diff;
    logic signed [CMP_W-1:0]    thr_pos;
    logic signed [CMP_W-1:0]    thr_neg;
    logic [WINDOW_W-1:0]        win_clamped;
    logic [DEBOUNCE_W-1:0]      window_end;
    logic                       swing_up;
    logic                       swing_down;
    logic                       tap;
    logic [DEBOUNCE_W-1:0]      left_cut;
    logic [CEXT_W-1:0]          count_ext;

    // Arithmetic shift right by one keeps the upper bits of the sample.
    assign half_now = z_sample[SAMPLE_WIDTH-1:1];

    assign diff    = CMP_W'(half_now) - CMP_W'(prev_half_reg);
    assign thr_pos = CMP_W'({1'b0, cfg.tap_threshold});
    assign thr_neg = -thr_pos;

    assign swing_up   = diff > thr_pos;
    assign swing_down = diff < thr_neg;

    assign win_clamped = (cfg.tap_window < cfg.debounce_length) ? cfg.tap_window
                                                                 : cfg.debounce_length;
    assign window_end  = cfg.debounce_length - win_clamped;

    always_comb begin
        prev_half_next     = half_now;
        debounce_left_next = debounce_left_reg;
        first_pos_next     = first_pos_reg;
        taps_next          = taps_reg;
        tap                = 1'b0;
        left_cut           = debounce_left_reg;
        if (debounce_left_reg == '0) begin
            // Idle: a swing either way arms the countdown.
            if (swing_up) begin
                debounce_left_next = cfg.debounce_length;
                first_pos_next     = 1'b1;
            end else if (swing_down) begin
                debounce_left_next = cfg.debounce_length;
                first_pos_next     = 1'b0;
            end
        end else begin
            // Busy: an opposite swing inside the window counts a tap and cuts
            // the countdown to the window end before the usual decrement.
            if ((debounce_left_reg > window_end) &&
                ((swing_up && !first_pos_reg) || (swing_down && first_pos_reg))) begin
                tap       = 1'b1;
                taps_next = taps_reg + COUNT_WIDTH'(1);
                left_cut  = window_end;
            end
            debounce_left_next = left_cut - DEBOUNCE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_half_reg     <= '0;
            debounce_left_reg <= '0;
            first_pos_reg     <= 1'b0;
            taps_reg          <= '0;
        end else if (step) begin
            prev_half_reg     <= prev_half_next;
            debounce_left_reg <= debounce_left_next;
            first_pos_reg     <= first_pos_next;
            taps_reg          <= taps_next;
        end
    end

    assign count_ext        = CEXT_W'(taps_next);
    assign result.tap_count = count_ext[TAP_COUNT_W-1:0];
    assign result.tap_seen  = tap;

endmodule

`default_nettype wire

@@ dv/accel_tap_detector_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the tap detector results and compares them with the result stream.
module accel_tap_detector_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [atd_pkg::TAP_COUNT_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [atd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [atd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                mismatch_count,
    output int                                results_owed
);

    typedef struct packed {
        logic [atd_pkg::TAP_COUNT_W-1:0] tap_count;
        logic                            tap_seen;
        logic                            report_now;
    } tap_report_t;

    // Shadow copy of the registers.
    logic [atd_pkg::THRESHOLD_W-1:0] swing_threshold;
    logic [atd_pkg::DEBOUNCE_W-1:0]  busy_length;
    logic [atd_pkg::WINDOW_W-1:0]    window_length;

    // Shadow copy of the detector state.
    logic signed [6:0]               last_half;
    logic [atd_pkg::DEBOUNCE_W-1:0]  busy_left;
    logic                            armed_rising;
    logic [atd_pkg::TAP_COUNT_W-1:0] tap_total;

    tap_report_t pending_reports[$];

    function automatic tap_report_t predict_tap(input logic [7:0] z, input logic burst_end);
        logic signed [6:0]              half_now;
        int                             swing;
        int                             limit;
        logic [atd_pkg::WINDOW_W-1:0]   span;
        logic [atd_pkg::DEBOUNCE_W-1:0] span_end;
        logic                           rise;
        logic                           fall;
        tap_report_t                    r;
        half_now = z[7:1];
        swing    = int'(half_now) - int'(last_half);
        limit    = int'(swing_threshold);
        // The window can never reach past the debounce period.
        span     = (window_length < busy_length) ? window_length : busy_length;
        span_end = busy_length - span;
        rise     = swing > limit;
        fall     = swing < -limit;
        r.tap_seen = 1'b0;
        last_half  = half_now;
        if (busy_left == '0) begin
            if (rise || fall) begin
                busy_left    = busy_length;
                armed_rising = rise;
            end
        end else begin
            if (busy_left > span_end &&
                ((rise && !armed_rising) || (fall && armed_rising))) begin
                tap_total  = tap_total + 1'b1;
                busy_left  = span_end;
                r.tap_seen = 1'b1;
            end
            busy_left = busy_left - 1'b1;
        end
        r.tap_count  = tap_total;
        r.report_now = burst_end;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        tap_report_t want;
        if (!aresetn) begin
            swing_threshold = atd_pkg::TAP_THRESHOLD_RESET;
            busy_length     = atd_pkg::DEBOUNCE_LENGTH_RESET;
            window_length   = atd_pkg::TAP_WINDOW_RESET;
            last_half       = '0;
            busy_left       = '0;
            armed_rising    = 1'b0;
            tap_total       = '0;
            pending_reports.delete();
            results_owed   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    atd_pkg::REG_TAP_THRESHOLD:   swing_threshold = cfg_data[6:0];
                    atd_pkg::REG_DEBOUNCE_LENGTH: busy_length     = cfg_data;
                    atd_pkg::REG_TAP_WINDOW:      window_length   = cfg_data;
                    default: ;
                endcase
            end
            // Results leave before the sample of this edge is predicted, since the
            // block registers every sample before it answers it.
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transfer: tap_count %0d tap_seen %0d",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("tap_count", want.tap_count, m_axis_tdata);
                    check_field("tap_seen", want.tap_seen, m_axis_tuser);
                    check_field("report_now", want.report_now, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_reports.push_back(predict_tap(s_axis_tdata, s_axis_tlast));
            end
            results_owed <= pending_reports.size();
        end
    end

endmodule

@@ dv/accel_tap_detector_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives samples and register writes into the tap detector and gives the verdict.
module accel_tap_detector_top_tb;

    // Index three is not decoded by the block; writes to it must change nothing.
    localparam logic [atd_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        READY_ALWAYS,
        READY_PATTERN,
        READY_RANDOM,
        READY_HOLD
    } ready_style_e;

    // One stretch of the run: register settings, how many samples to send, and
    // whether the samples alternate between the rails to force a tap on nearly
    // every second sample. When shuffle is set the registers are drawn at random.
    typedef struct {
        int threshold;
        int debounce;
        int window;
        int items;
        bit alternate;
        bit shuffle;
    } phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [atd_pkg::TAP_COUNT_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [atd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [atd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int results_owed;

    // Sender burst bookkeeping and the sample generator's memory.
    int burst_left = 0;
    int z_prev = 0;
    bit swing_up = 1'b0;

    // Receiver stall pattern bookkeeping.
    ready_style_e ready_style = READY_ALWAYS;
    int           style_left = 0;
    logic [3:0]   pattern_tick = '0;

    // A 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    accel_tap_detector_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    accel_tap_detector_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // The receiver switches between stall styles at random intervals: always
    // ready, a fixed three-in-four pattern, coin flips, and a long hold that
    // backs results up into the block before releasing them at its end.
    always @(negedge aclk) begin
        if (style_left == 0) begin
            ready_style <= ready_style_e'($urandom_range(0, 3));
            style_left  <= $urandom_range(16, 96);
        end else begin
            style_left <= style_left - 1;
        end
        pattern_tick <= pattern_tick + 1'b1;
        case (ready_style)
            READY_ALWAYS:  m_axis_tready <= 1'b1;
            READY_PATTERN: m_axis_tready <= (pattern_tick[1:0] != 2'b11);
            READY_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
            READY_HOLD:    m_axis_tready <= (style_left < 4);
            default:       m_axis_tready <= 1'b1;
        endcase
    end

    // Writes one register. The task starts and ends on a falling edge and leaves
    // cfg_valid high, so that back-to-back writes never lower and raise it within
    // one time step; the caller drops it after the last write.
    task automatic write_reg(input logic [atd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [atd_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Sends one sample transfer. The sender runs in bursts; at the start of each
    // new burst it may drop tvalid for a random gap. tvalid stays high across
    // consecutive samples of a burst.
    task automatic send_sample(input int z, input logic burst_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z[7:0];
        s_axis_tlast  <= burst_end;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted result has been received.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Produces the next raw Z sample. In the alternating mode the samples jump
    // between near-full-scale positive and negative values, with a rare random
    // sample to break the rhythm. Otherwise the stream mixes uniform noise, small
    // jitter around the last value, and large swings whose direction alternates,
    // so that first swings are often followed by an opposite swing.
    function automatic int next_sample(input bit alternate);
        int z;
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (alternate) begin
            swing_up = !swing_up;
            if ($urandom_range(0, 31) == 0) begin
                z = int'($urandom_range(0, 255)) - 128;
            end else if (swing_up) begin
                z = 127 - int'($urandom_range(0, 12));
            end else begin
                z = -128 + int'($urandom_range(0, 12));
            end
        end else if (pick < 2) begin
            z = int'($urandom_range(0, 255)) - 128;
        end else if (pick < 5) begin
            z = z_prev + int'($urandom_range(0, 12)) - 6;
        end else begin
            swing_up = !swing_up;
            mag = $urandom_range(10, 200);
            z = swing_up ? z_prev + mag : z_prev - mag;
        end
        if (z > 127) begin
            z = 127;
        end else if (z < -128) begin
            z = -128;
        end
        z_prev = z;
        return z;
    endfunction

    initial begin : stimulus
        phase_t     plan [9];
        phase_t     p;
        logic [7:0] thr_bits;
        // Settings run from the reset values through both extremes of every
        // register, a zero debounce length, a window equal to and wider than the
        // debounce length, a fast-tapping stretch that wraps the tap count, and
        // two stretches with random registers.
        plan[0] = '{20, 45, 5, 160, 1'b0, 1'b0};
        plan[1] = '{0, 1, 0, 100, 1'b0, 1'b0};
        plan[2] = '{127, 255, 255, 80, 1'b0, 1'b0};
        plan[3] = '{10, 3, 2, 560, 1'b1, 1'b0};
        plan[4] = '{3, 0, 7, 80, 1'b0, 1'b0};
        plan[5] = '{5, 8, 8, 120, 1'b0, 1'b0};
        plan[6] = '{30, 20, 40, 140, 1'b0, 1'b0};
        plan[7] = '{0, 0, 0, 80, 1'b0, 1'b1};
        plan[8] = '{0, 0, 0, 80, 1'b0, 1'b1};

        // Synchronous reset, held low at the start and then released.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed samples with the reset settings: a rising first swing followed
        // by a falling one inside the window counts a tap, then further swings
        // while the countdown is past the window are ignored. The samples also
        // touch both rails and zero.
        send_sample(0, 1'b0);
        send_sample(100, 1'b0);
        send_sample(-100, 1'b1);
        send_sample(127, 1'b0);
        send_sample(-128, 1'b1);

        // Shrink the debounce length and window while the countdown is still
        // high: the countdown keeps its value and is judged against the new
        // window end, so a falling swing now counts as a tap.
        wait_drained();
        write_reg(atd_pkg::REG_DEBOUNCE_LENGTH, 8'd4);
        write_reg(atd_pkg::REG_TAP_WINDOW, 8'd2);
        cfg_valid <= 1'b0;
        send_sample(0, 1'b0);
        send_sample(-128, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(-1, 1'b0);
        // A falling first swing answered by a rising one.
        send_sample(-100, 1'b0);
        send_sample(1, 1'b1);
        send_sample(1, 1'b0);
        // A rising first swing whose opposite swing comes just after the window
        // closes and must not count.
        send_sample(127, 1'b0);
        send_sample(126, 1'b0);
        send_sample(125, 1'b0);
        send_sample(-128, 1'b1);
        send_sample(2, 1'b0);
        send_sample(2, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            p = plan[ph];
            if (p.shuffle) begin
                p.threshold = $urandom_range(0, 127);
                p.debounce  = $urandom_range(0, 255);
                p.window    = $urandom_range(0, 255);
            end
            // The top bit of a threshold write is not stored, so it is driven
            // at random.
            thr_bits    = 8'(p.threshold);
            thr_bits[7] = 1'($urandom_range(0, 1));
            write_reg(atd_pkg::REG_TAP_THRESHOLD, thr_bits);
            write_reg(atd_pkg::REG_DEBOUNCE_LENGTH, 8'(p.debounce));
            write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            write_reg(atd_pkg::REG_TAP_WINDOW, 8'(p.window));
            cfg_valid <= 1'b0;
            for (int i = 0; i < p.items; i++) begin
                // Once in the run, stop halfway and let the result side empty.
                if (ph == 0 && i == p.items / 2) begin
                    wait_drained();
                end
                send_sample(next_sample(p.alternate), 1'($urandom_range(0, 3) == 0));
            end
            wait_drained();
        end

        if (mismatch_count == 0 && results_owed == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 1400 samples.
    initial begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/atd_pkg.sv
rtl/atd_cfg_regs.sv
rtl/atd_core.sv
rtl/accel_tap_detector_top.sv
dv/accel_tap_detector_checker.sv
dv/accel_tap_detector_top_tb.sv
